>>> design/serial_lcd_command_writer_assert.svh
// Assertion macros shared by the serial LCD command writer RTL.
// Depends on nothing; the including module must provide aclk and aresetn.
`ifndef SERIAL_LCD_COMMAND_WRITER_ASSERT_SVH
`define SERIAL_LCD_COMMAND_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/slcw_pkg.sv
// Package for the serial LCD command writer: beat types, action codes,
// protocol bytes and register map. No dependencies.
package slcw_pkg;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_CMD  = 2'd1;
    localparam logic [1:0] ACT_DATA = 2'd2;

    localparam logic [7:0] SYNC_CMD    = 8'hF8;
    localparam logic [7:0] SYNC_DATA   = 8'hFA;
    localparam logic [7:0] STATUS_READ = 8'hFC;
    localparam logic [7:0] BUSY_MASK   = 8'h80;
    localparam logic [7:0] NIBBLE_HI   = 8'hF0;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0] REG_PHASE_TICKS = 1'b0;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] value;
        logic       sid_in;
    } in_item_t;

    typedef struct packed {
        logic       chip_select;
        logic       serial_clock;
        logic       serial_data;
        logic       in_transfer;
        logic       write_done;
        logic [7:0] last_status;
    } out_item_t;

endpackage

>>> design/serial_lcd_command_writer.sv
// Top level of the serial LCD command writer: input stage, sequencer, result stage.
// Depends on slcw_pkg, slcw_cfg, slcw_core and serial_lcd_command_writer_assert.svh.
//
// Usage:
// - Every input beat (s_valid/s_ready, payload s_payload) is one timing tick
//   for the three-wire display link. action selects a plain tick, a command
//   write or a data write; a start is honored only while no transfer runs.
// - Each input beat yields exactly one result beat on m_valid/m_ready, carrying
//   the pin levels after that tick, the transfer flag, a done pulse and the
//   last status byte read back from the display.
// - A beat enters the input register on acceptance; the sequencer result is
//   captured in the result register when the beat moves on (result stage free
//   or draining), and the result is offered from there.
// - Throughput: one beat per cycle while m_ready stays high; the sequencer state
//   update is a single pass of short logic between the input and result registers.
// - A stalled receiver holds the result register; the input register still
//   takes one more beat, then s_ready drops until the result is taken.
// - The APB port holds phase_ticks (address 0), ticks per clock phase; write it
//   only while idle. Reset (aresetn low, synchronous) returns the sequencer to
//   idle with all pins low, empties both stages and sets phase_ticks to 5.
`include "serial_lcd_command_writer_assert.svh"

module serial_lcd_command_writer
    import slcw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_payload,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_data_reg;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_payload_reg;
    logic        advance;
    logic        fire;
    logic        s_take;
    logic [15:0] phase_ticks;
    out_item_t   core_result;

    slcw_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .phase_ticks (phase_ticks)
    );

    // Result stage free or draining this cycle: move the input beat on.
    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    slcw_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (in_data_reg),
        .phase_ticks (phase_ticks),
        .result      (core_result)
    );

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: load on their stage's handshake, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_payload;
        end
        if (fire) begin
            m_payload_reg <= core_result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `SLCW_ASSERT_NOW(a_done_drops_select, m_valid && m_payload.write_done,
        !m_payload.chip_select && !m_payload.in_transfer,
        "write_done beat with select or transfer still high")
    `SLCW_ASSERT_NOW(a_select_tracks_transfer, m_valid,
        m_payload.chip_select == m_payload.in_transfer,
        "chip select disagrees with transfer flag")
    `SLCW_ASSERT_NOW(a_full_stall_blocks_input, in_valid_reg && m_valid_reg && !m_ready,
        !s_ready && !fire, "beat moved while both stages stalled")
    `SLCW_ASSERT_NEXT(a_fire_fills_result, fire, m_valid,
        "sequencer stepped without a result beat")

endmodule

>>> design/slcw_cfg.sv
// APB-style register file of the serial LCD command writer (phase length).
// Depends on slcw_pkg.
module slcw_cfg
    import slcw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [15:0]        phase_ticks
);

    logic [15:0] phase_ticks_reg;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_PHASE_TICKS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end else if (wr_hit) begin
            phase_ticks_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr[PADDR_W-1] == REG_PHASE_TICKS) begin
            prdata = {16'd0, phase_ticks_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    assign phase_ticks = phase_ticks_reg;

endmodule

>>> design/slcw_core.sv
// Transfer sequencer: poll, receive status, send sync and nibbles, one tick per beat.
// Depends on slcw_pkg.
module slcw_core
    import slcw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    input  logic [15:0] phase_ticks,
    output out_item_t result
);

    typedef enum logic [3:0] {
        STEP_IDLE  = 4'd0,
        STEP_POLL  = 4'd1,
        STEP_RX1   = 4'd2,
        STEP_RX2   = 4'd3,
        STEP_FRAME = 4'd4
    } step_t;

    step_t       step_reg, step_next;
    logic [4:0]  bit_reg, bit_next;
    logic [7:0]  tx_reg, tx_next;
    logic [1:0]  fbi_reg, fbi_next;
    logic [7:0]  pend_reg, pend_next;
    logic        pdata_reg, pdata_next;
    logic [7:0]  rx1_reg, rx1_next;
    logic [7:0]  rx2_reg, rx2_next;
    logic [15:0] phc_reg, phc_next;
    logic [7:0]  status_reg, status_next;
    logic        cs_reg, cs_next;
    logic        sck_reg, sck_next;
    logic        sid_reg, sid_next;
    logic        done;

    logic        rx;
    logic [1:0]  phase;
    logic [16:0] len;
    logic [16:0] phc_inc;

    assign rx      = (step_reg == STEP_RX1) || (step_reg == STEP_RX2);
    assign phase   = bit_reg[1:0];
    assign len     = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};
    assign phc_inc = {1'b0, phc_reg} + 17'd1;

    always_comb begin
        step_next   = step_reg;
        bit_next    = bit_reg;
        tx_next     = tx_reg;
        fbi_next    = fbi_reg;
        pend_next   = pend_reg;
        pdata_next  = pdata_reg;
        rx1_next    = rx1_reg;
        rx2_next    = rx2_reg;
        phc_next    = phc_reg;
        status_next = status_reg;
        cs_next     = cs_reg;
        sck_next    = sck_reg;
        sid_next    = sid_reg;
        done        = 1'b0;

        case (step_reg)
            STEP_IDLE: begin
                if (item.action == ACT_CMD || item.action == ACT_DATA) begin
                    pend_next  = item.value;
                    pdata_next = (item.action == ACT_DATA);
                    cs_next    = 1'b1;
                    step_next  = STEP_POLL;
                    tx_next    = STATUS_READ;
                    bit_next   = 5'd0;
                    phc_next   = 16'd0;
                    fbi_next   = 2'd0;
                end
            end
            STEP_POLL, STEP_RX1, STEP_RX2, STEP_FRAME: begin
                // Phase entry actions on the first tick of a phase.
                if (phc_reg == 16'd0) begin
                    if (rx) begin
                        if (phase != 2'd0) begin
                            sck_next = (phase == 2'd2);
                        end
                    end else begin
                        case (phase)
                            2'd0:    sck_next = 1'b0;
                            2'd1:    sid_next = tx_reg[7];
                            2'd2:    tx_next  = {tx_reg[6:0], 1'b0};
                            default: sck_next = 1'b1;
                        endcase
                    end
                end
                if (phc_inc < len) begin
                    phc_next = phc_inc[15:0];
                end else begin
                    phc_next = 16'd0;
                    if (phase == 2'd3) begin
                        if (!rx) begin
                            sck_next = 1'b0;
                        end else if (step_reg == STEP_RX1) begin
                            rx1_next = {rx1_reg[6:0], item.sid_in};
                        end else begin
                            rx2_next = {rx2_reg[6:0], item.sid_in};
                        end
                    end
                    bit_next = bit_reg + 5'd1;
                    // Byte boundary: pick the next byte of the sequence.
                    if (bit_next == 5'd0) begin
                        case (step_reg)
                            STEP_POLL: step_next = STEP_RX1;
                            STEP_RX1:  step_next = STEP_RX2;
                            STEP_RX2: begin
                                status_next = (rx1_next & NIBBLE_HI) | {4'd0, rx2_next[7:4]};
                                if ((status_next & BUSY_MASK) != 8'd0) begin
                                    step_next = STEP_POLL;
                                    tx_next   = STATUS_READ;
                                end else begin
                                    step_next = STEP_FRAME;
                                    fbi_next  = 2'd0;
                                    tx_next   = pdata_reg ? SYNC_DATA : SYNC_CMD;
                                end
                            end
                            default: begin
                                fbi_next = fbi_reg + 2'd1;
                                if (fbi_next == 2'd1) begin
                                    tx_next = pend_reg & NIBBLE_HI;
                                end else if (fbi_next == 2'd2) begin
                                    tx_next = {pend_reg[3:0], 4'd0};
                                end else begin
                                    cs_next   = 1'b0;
                                    step_next = STEP_IDLE;
                                    fbi_next  = 2'd0;
                                    done      = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= STEP_IDLE;
            bit_reg    <= 5'd0;
            tx_reg     <= 8'd0;
            fbi_reg    <= 2'd0;
            pend_reg   <= 8'd0;
            pdata_reg  <= 1'b0;
            rx1_reg    <= 8'd0;
            rx2_reg    <= 8'd0;
            phc_reg    <= 16'd0;
            status_reg <= 8'd0;
            cs_reg     <= 1'b0;
            sck_reg    <= 1'b0;
            sid_reg    <= 1'b0;
        end else if (fire) begin
            step_reg   <= step_next;
            bit_reg    <= bit_next;
            tx_reg     <= tx_next;
            fbi_reg    <= fbi_next;
            pend_reg   <= pend_next;
            pdata_reg  <= pdata_next;
            rx1_reg    <= rx1_next;
            rx2_reg    <= rx2_next;
            phc_reg    <= phc_next;
            status_reg <= status_next;
            cs_reg     <= cs_next;
            sck_reg    <= sck_next;
            sid_reg    <= sid_next;
        end
    end

    always_comb begin
        result.chip_select  = cs_next;
        result.serial_clock = sck_next;
        result.serial_data  = sid_next;
        result.in_transfer  = (step_next != STEP_IDLE);
        result.write_done   = done;
        result.last_status  = status_next;
    end

endmodule

>>> tb/serial_lcd_command_writer_test.sv
// Self-checking testbench for serial_lcd_command_writer: ticks, writes and busy polls.
// Depends on slcw_pkg and the serial_lcd_command_writer RTL; reads and writes no files.
// A cycle-exact model of the display link predicts one pin-level beat per tick.
module serial_lcd_command_writer_test;
    import slcw_pkg::*;

    // Action code that the block must treat as a plain tick.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Register map: one 32-bit register per word.
    localparam logic [PADDR_W-1:0] ADDR_PHASE_TICKS = {REG_PHASE_TICKS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNUSED      = 3'd4;

    localparam int CYCLE_LIMIT    = 40_000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [2:0] {ST_IDLE, ST_POLL, ST_RX1, ST_RX2, ST_FRAME} seq_step_e;
    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_e;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_payload = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_payload;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    serial_lcd_command_writer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Display link model: sequencer state, shift registers and pin levels.
    seq_step_e   step_q    = ST_IDLE;
    logic [4:0]  bit_cnt   = '0;
    logic [7:0]  shift_q   = '0;
    logic [1:0]  frame_idx = '0;
    logic [7:0]  pend_byte = '0;
    logic        pend_data = 1'b0;
    logic [7:0]  rx_first  = '0;
    logic [7:0]  rx_second = '0;
    logic [15:0] phase_cnt = '0;
    logic [7:0]  status_q  = '0;
    logic        cs_q      = 1'b0;
    logic        sck_q     = 1'b0;
    logic        sid_q     = 1'b0;
    logic [15:0] ticks_cfg = PHASE_TICKS_RESET;

    out_item_t   expected_pins[$];
    out_item_t   want;
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;

    // Sender burst shaping; steady suppresses gaps.
    int          burst_left = 0;
    bit          steady     = 1'b0;
    // Busy status replies still to give in the running transfer.
    int          busy_left  = 0;

    // Receiver stall request from the tests, served by the receiver process.
    bit          stall_req  = 1'b0;
    int          stall_len  = 0;
    int          stall_left = 0;
    rdy_mode_e   rdy_mode   = RDY_ALWAYS;
    int          mode_left  = 0;
    int          pat_cnt    = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                   input logic [15:0] got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_cnt, what, exp_v, got_v);
    endtask

    task automatic check_field(input string what, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
            report_mismatch(what, exp_v, got_v);
    endtask

    // Advance the link model by one tick and return the pin levels after it.
    task automatic step_lcd_link(input in_item_t it, output out_item_t pins);
        logic        rx;
        logic        done;
        logic [1:0]  ph;
        logic [15:0] len;
        done = 1'b0;
        if (step_q == ST_IDLE) begin
            // A start only takes effect from idle; action three is a plain tick.
            if (it.action == ACT_CMD || it.action == ACT_DATA) begin
                pend_byte = it.value;
                pend_data = (it.action == ACT_DATA);
                cs_q      = 1'b1;
                step_q    = ST_POLL;
                shift_q   = STATUS_READ;
                bit_cnt   = '0;
                phase_cnt = '0;
                frame_idx = '0;
            end
        end else begin
            rx  = (step_q == ST_RX1 || step_q == ST_RX2);
            ph  = bit_cnt[1:0];
            // A zero phase length runs as one tick per phase.
            len = (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg;
            if (phase_cnt == 16'd0) begin
                if (rx) begin
                    if (ph != 2'd0)
                        sck_q = (ph == 2'd2);
                end else begin
                    case (ph)
                        2'd0: sck_q = 1'b0;
                        2'd1: sid_q = shift_q[7];
                        2'd2: shift_q = shift_q << 1;
                        default: sck_q = 1'b1;
                    endcase
                end
            end
            phase_cnt = phase_cnt + 16'd1;
            if (phase_cnt >= len) begin
                phase_cnt = '0;
                if (ph == 2'd3) begin
                    if (!rx)
                        sck_q = 1'b0;
                    else if (step_q == ST_RX1)
                        rx_first = {rx_first[6:0], it.sid_in};
                    else
                        rx_second = {rx_second[6:0], it.sid_in};
                end
                bit_cnt = bit_cnt + 5'd1;
                if (bit_cnt == 5'd0) begin
                    // End of a byte: move through poll, both reads, then the frame.
                    case (step_q)
                        ST_POLL: step_q = ST_RX1;
                        ST_RX1:  step_q = ST_RX2;
                        ST_RX2: begin
                            status_q = (rx_first & NIBBLE_HI) | (rx_second >> 4);
                            if ((status_q & BUSY_MASK) != 8'h00) begin
                                step_q  = ST_POLL;
                                shift_q = STATUS_READ;
                            end else begin
                                step_q    = ST_FRAME;
                                frame_idx = '0;
                                shift_q   = pend_data ? SYNC_DATA : SYNC_CMD;
                            end
                        end
                        default: begin
                            frame_idx = frame_idx + 2'd1;
                            if (frame_idx == 2'd1) begin
                                shift_q = pend_byte & NIBBLE_HI;
                            end else if (frame_idx == 2'd2) begin
                                shift_q = (pend_byte << 4) & NIBBLE_HI;
                            end else begin
                                cs_q      = 1'b0;
                                step_q    = ST_IDLE;
                                frame_idx = '0;
                                done      = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
        pins.chip_select  = cs_q;
        pins.serial_clock = sck_q;
        pins.serial_data  = sid_q;
        pins.in_transfer  = (step_q != ST_IDLE);
        pins.write_done   = done;
        pins.last_status  = status_q;
    endtask

    // Offer one tick; gaps fall between random-length bursts unless steady.
    task automatic send_tick(input in_item_t it);
        out_item_t pins;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!steady) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        step_lcd_link(it, pins);
        expected_pins.push_back(pins);
    endtask

    // Drive one tick of a running transfer. The first received bit of a status
    // reply decides busy, so hold it high while busy replies remain.
    task automatic drive_tick(input bit noisy);
        in_item_t  it;
        seq_step_e was;
        it.action = noisy ? 2'($urandom_range(0, 3)) : ACT_TICK;
        it.value  = 8'($urandom);
        if (step_q == ST_RX1 && bit_cnt[4:2] == 3'd0)
            it.sid_in = (busy_left != 0);
        else
            it.sid_in = 1'($urandom);
        was = step_q;
        send_tick(it);
        if (was == ST_RX2 && step_q == ST_POLL)
            busy_left--;
    endtask

    // One whole write from idle: start beat, busy polls, frame, select drop.
    task automatic run_write(input logic [1:0] act, input logic [7:0] val,
                             input int polls, input bit noisy);
        busy_left = polls;
        send_tick('{action: act, value: val, sid_in: 1'($urandom)});
        while (step_q != ST_IDLE)
            drive_tick(noisy);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n)
            send_tick('{action: ($urandom_range(0, 1) != 0) ? ACT_UNUSED : ACT_TICK,
                        value: 8'($urandom), sid_in: 1'($urandom)});
    endtask

    // Drop valid and hold until every expected beat has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr, input logic [15:0] exp_v);
        apb_access(1'b0, addr, 32'h0);
        check_field("register read", exp_v, prdata[15:0]);
    endtask

    // Finish any running transfer and drain before touching the register.
    task automatic set_phase_ticks(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        while (step_q != ST_IDLE)
            drive_tick(1'b0);
        wait_drained();
        apb_access(1'b1, addr, data);
        if (addr == ADDR_PHASE_TICKS)
            ticks_cfg = data[15:0];
    endtask

    // Receiver: serve stall requests, otherwise rotate through ready patterns.
    always @(posedge aclk) begin
        if (stall_req) begin
            stall_left = stall_len;
            stall_req  = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  = rdy_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            pat_cnt++;
            case (rdy_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default:    m_ready <= ((pat_cnt % 5) != 2) && ((pat_cnt % 11) != 7);
            endcase
        end
    end

    // Compare every returned beat with the oldest prediction, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pins.size() == 0) begin
                report_mismatch("beat with nothing expected", 16'h0, 16'(m_payload));
            end else begin
                want = expected_pins.pop_front();
                check_field("chip_select", 16'(want.chip_select), 16'(m_payload.chip_select));
                check_field("serial_clock", 16'(want.serial_clock),
                            16'(m_payload.serial_clock));
                check_field("serial_data", 16'(want.serial_data), 16'(m_payload.serial_data));
                check_field("in_transfer", 16'(want.in_transfer), 16'(m_payload.in_transfer));
                check_field("write_done", 16'(want.write_done), 16'(m_payload.write_done));
                check_field("last_status", 16'(want.last_status), 16'(m_payload.last_status));
            end
        end
    end

    // Reset value, unmapped address and masking of the upper data bits.
    task automatic test_register_map();
        apb_read_check(ADDR_PHASE_TICKS, PHASE_TICKS_RESET);
        set_phase_ticks(ADDR_UNUSED, 32'h0000_0009);
        apb_read_check(ADDR_PHASE_TICKS, PHASE_TICKS_RESET);
        set_phase_ticks(ADDR_PHASE_TICKS, 32'hFFFF_0001);
        apb_read_check(ADDR_PHASE_TICKS, 16'd1);
    endtask

    // Top byte as data with a busy reply and ignored starts; plain and unused ticks.
    task automatic test_directed_writes();
        send_tick('{action: ACT_UNUSED, value: 8'hFF, sid_in: 1'b1});
        send_tick('{action: ACT_TICK, value: 8'h00, sid_in: 1'b0});
        run_write(ACT_DATA, 8'hFF, 1, 1'b1);
    endtask

    // Zero byte as a command at zero phase length, then the longest and a
    // two-tick phase, which the following tests run at.
    task automatic test_phase_lengths();
        set_phase_ticks(ADDR_PHASE_TICKS, 32'h0000_0000);
        run_write(ACT_CMD, 8'h00, 0, 1'b0);
        set_phase_ticks(ADDR_PHASE_TICKS, 32'h0000_FFFF);
        apb_read_check(ADDR_PHASE_TICKS, 16'hFFFF);
        idle_ticks(12);
        set_phase_ticks(ADDR_PHASE_TICKS, 32'h0000_0002);
    endtask

    // Long receiver hold with the sender offering back to back: input must stall.
    task automatic test_receiver_hold();
        steady    = 1'b1;
        stall_len = 80;
        stall_req = 1'b1;
        idle_ticks(30);
        steady    = 1'b0;
    endtask

    // Pause mid-transfer until all results are back, then carry on.
    task automatic test_sender_pause();
        busy_left = 0;
        send_tick('{action: ACT_DATA, value: 8'($urandom), sid_in: 1'b0});
        repeat (50) drive_tick(1'b0);
        wait_drained();
        while (step_q != ST_IDLE)
            drive_tick(1'b1);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_map();
        test_directed_writes();
        test_phase_lengths();
        test_receiver_hold();
        test_sender_pause();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/slcw_pkg.sv
design/slcw_cfg.sv
design/slcw_core.sv
design/serial_lcd_command_writer.sv
tb/serial_lcd_command_writer_test.sv
